### hdl/sdci_pkg.sv
// types and constants of the sd card bring-up sequencer
package sdci_pkg;

	// sequencer steps, named after the command whose completion is awaited
	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_CMD0   = 4'd1,
		ST_CMD8   = 4'd2,
		ST_APP41  = 4'd3,
		ST_ACMD41 = 4'd4,
		ST_CMD2   = 4'd5,
		ST_CMD3   = 4'd6,
		ST_CMD9   = 4'd7,
		ST_CMD7   = 4'd8,
		ST_APP6   = 4'd9,
		ST_ACMD6  = 4'd10,
		ST_DONE   = 4'd11,
		ST_FAIL   = 4'd12
	} step_t;

	// expected response kind
	typedef enum logic [2:0] {
		RK_NONE = 3'd0,
		RK_R1   = 3'd1,
		RK_R1B  = 3'd2,
		RK_R2   = 3'd3,
		RK_R3   = 3'd4,
		RK_R6   = 3'd5,
		RK_R7   = 3'd6
	} resp_kind_t;

	// input selector
	localparam logic MODE_START = 1'b0;

	// command indexes
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_ALL_CID   = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
	localparam logic [5:0] ACMD_BUS_WID  = 6'd6;
	localparam logic [5:0] CMD_SELECT    = 6'd7;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
	localparam logic [5:0] ACMD_OP_COND  = 6'd41;
	localparam logic [5:0] CMD_APP_CMD   = 6'd55;

	// arguments and checked values
	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_OCR_BASE = 32'h0002_0000;
	localparam logic [31:0] ARG_OCR_HCS  = 32'h4000_0000;
	localparam logic [31:0] ARG_BUS_4BIT = 32'h0000_0002;
	localparam logic [31:0] STATUS_TRAN  = 32'h0000_0920;

	localparam int          OCR_BUSY_BIT = 31;
	localparam int          OCR_CCS_BIT  = 30;

	localparam logic [15:0] RETRY_RESET  = 16'd1000;
	localparam logic [15:0] RETRY_MAX    = 16'hFFFF;

	// register indexes
	localparam logic REG_RETRY_LIMIT = 1'b0;

	typedef struct packed {
		logic [15:0] card_addr;
		logic        spec_v2;
		logic        high_capacity;
		logic        failed;
		logic        done_res;
		resp_kind_t  resp_kind;
		logic [31:0] cmd_arg;
		logic [5:0]  cmd_index;
		logic        issue;
	} result_t;

endpackage

### hdl/sd_card_init_sequencer.sv
// sd card bring-up sequencer top level
//
// host-side sd card bring-up: a start transfer (tuser 0) asks for CMD0, and
// every completion transfer (tuser 1) reports the error flag and first
// response word of the command asked for last. each input transfer gives
// exactly one result transfer with the next command to send (or none), the
// done and failed flags and the card facts found so far (spec version,
// capacity, relative card address). the block takes one transfer per clock
// while the result side keeps up: an input register feeds one level of decode
// logic into the output register, which holds each result until it is taken.
// while a result waits there, the input register still takes one
// more transfer, then s_tready stays low until the waiting result is taken.
// the acmd41 poll loop is bounded by retry_limit (apb address 0, reset 1000);
// write it only while no transfer is in flight.
module sd_card_init_sequencer
	import sdci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cmd_error [0], resp_word [32:1], zero pad
	input  logic        s_tuser,  // mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// issue [0], cmd_index [6:1], cmd_arg [38:7], resp_kind [41:39],
	// done_res [42], failed [43], high_capacity [44], spec_v2 [45],
	// card_addr [61:46], zero pad
	output logic [63:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration register
	logic [15:0] retry_limit_q;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_RETRY_LIMIT) begin
			retry_limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_RETRY_LIMIT) begin
			prdata = {16'd0, retry_limit_q};
		end
	end

	// input register
	logic        valid_s1;
	logic        mode_s1;
	logic        err_s1;
	logic [31:0] resp_s1;
	logic        advance;

	// output register
	logic        valid_s2;
	result_t     res_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			err_s1  <= s_tdata[0];
			resp_s1 <= s_tdata[32:1];
		end
	end

	// sequencer state
	step_t       step_q, step_d;
	logic [15:0] retry_q, retry_d;
	logic        v2_q, v2_d;
	logic        hc_q, hc_d;
	logic [15:0] rca_q, rca_d;

	// shared decode
	logic        start;
	logic        in_flight;     // a command is outstanding
	logic        cmd_fail;      // error on a command other than cmd8
	logic        poll_ok;       // another acmd41 round is allowed
	logic        ocr_ready;
	logic [31:0] rca_arg;

	assign start     = (mode_s1 == MODE_START);
	assign in_flight = (step_q >= ST_CMD0) && (step_q <= ST_ACMD6);
	assign cmd_fail  = in_flight && err_s1 && (step_q != ST_CMD8);
	assign poll_ok   = (retry_q <= retry_limit_q);
	assign ocr_ready = resp_s1[OCR_BUSY_BIT];
	assign rca_arg   = {rca_q, 16'd0};

	// next state
	always_comb begin
		step_d  = step_q;
		retry_d = retry_q;
		v2_d    = v2_q;
		hc_d    = hc_q;
		rca_d   = rca_q;
		if (start) begin
			step_d  = ST_CMD0;
			retry_d = '0;
			v2_d    = 1'b0;
			hc_d    = 1'b0;
			rca_d   = '0;
		end else if (cmd_fail) begin
			step_d = ST_FAIL;
		end else begin
			case (step_q)
				ST_CMD0:   step_d = ST_CMD8;
				ST_CMD8: begin
					// no answer to cmd8 means a version 1 card
					v2_d = !err_s1;
					if (poll_ok) begin
						step_d = ST_APP41;
						if (retry_q != RETRY_MAX) retry_d = retry_q + 16'd1;
					end else begin
						step_d = ST_FAIL;
					end
				end
				ST_APP41:  step_d = ST_ACMD41;
				ST_ACMD41: begin
					if (ocr_ready) begin
						hc_d   = v2_q && resp_s1[OCR_CCS_BIT];
						step_d = ST_CMD2;
					end else if (poll_ok) begin
						step_d = ST_APP41;
						if (retry_q != RETRY_MAX) retry_d = retry_q + 16'd1;
					end else begin
						step_d = ST_FAIL;
					end
				end
				ST_CMD2:   step_d = ST_CMD3;
				ST_CMD3: begin
					rca_d  = resp_s1[31:16];
					step_d = ST_CMD9;
				end
				ST_CMD9:   step_d = ST_CMD7;
				ST_CMD7:   step_d = ST_APP6;
				ST_APP6:   step_d = ST_ACMD6;
				ST_ACMD6:  step_d = (resp_s1 == STATUS_TRAN) ? ST_DONE : ST_FAIL;
				default:   step_d = step_q;
			endcase
		end
	end

	// command to issue
	result_t res_d;

	always_comb begin
		res_d               = '0;
		res_d.resp_kind     = RK_NONE;
		if (start) begin
			res_d.issue     = 1'b1;
			res_d.cmd_index = CMD_GO_IDLE;
		end else if (!cmd_fail) begin
			case (step_q)
				ST_CMD0: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = CMD_IF_COND;
					res_d.cmd_arg   = ARG_IF_COND;
					res_d.resp_kind = RK_R7;
				end
				ST_CMD8: begin
					if (poll_ok) begin
						res_d.issue     = 1'b1;
						res_d.cmd_index = CMD_APP_CMD;
						res_d.resp_kind = RK_R1;
					end
				end
				ST_APP41: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = ACMD_OP_COND;
					res_d.cmd_arg   = v2_q ? (ARG_OCR_HCS | ARG_OCR_BASE) : ARG_OCR_BASE;
					res_d.resp_kind = RK_R3;
				end
				ST_ACMD41: begin
					if (ocr_ready) begin
						res_d.issue     = 1'b1;
						res_d.cmd_index = CMD_ALL_CID;
						res_d.resp_kind = RK_R2;
					end else if (poll_ok) begin
						res_d.issue     = 1'b1;
						res_d.cmd_index = CMD_APP_CMD;
						res_d.resp_kind = RK_R1;
					end
				end
				ST_CMD2: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = CMD_SEND_RCA;
					res_d.resp_kind = RK_R6;
				end
				ST_CMD3: begin
					// new address goes out with this very command
					res_d.issue     = 1'b1;
					res_d.cmd_index = CMD_SEND_CSD;
					res_d.cmd_arg   = {resp_s1[31:16], 16'd0};
					res_d.resp_kind = RK_R2;
				end
				ST_CMD9: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = CMD_SELECT;
					res_d.cmd_arg   = rca_arg;
					res_d.resp_kind = RK_R1B;
				end
				ST_CMD7: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = CMD_APP_CMD;
					res_d.cmd_arg   = rca_arg;
					res_d.resp_kind = RK_R1;
				end
				ST_APP6: begin
					res_d.issue     = 1'b1;
					res_d.cmd_index = ACMD_BUS_WID;
					res_d.cmd_arg   = ARG_BUS_4BIT;
					res_d.resp_kind = RK_R1;
				end
				default: res_d.issue = 1'b0;
			endcase
		end
		// status reflects the state after this transfer
		res_d.done_res      = (step_d == ST_DONE);
		res_d.failed        = (step_d == ST_FAIL);
		res_d.high_capacity = hc_d;
		res_d.spec_v2       = v2_d;
		res_d.card_addr     = rca_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_IDLE;
			retry_q  <= '0;
			v2_q     <= 1'b0;
			hc_q     <= 1'b0;
			rca_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				step_q   <= step_d;
				retry_q  <= retry_d;
				v2_q     <= v2_d;
				hc_q     <= hc_d;
				rca_q    <= rca_d;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2};

	// a decoded transfer always lands in the output register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("decoded transfer not presented");

	// no command goes out once bring-up has ended
	a_issue_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.issue) |-> (!res_s2.done_res && !res_s2.failed))
		else $error("command issued after bring-up ended");

	// an idle result carries a cleared command
	a_no_issue_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.issue) |->
			(res_s2.cmd_index == '0 && res_s2.cmd_arg == '0 && res_s2.resp_kind == RK_NONE))
		else $error("stray command fields without issue");

	// a version 1 card is never reported as high capacity
	a_v1_standard: assert property (@(posedge clk) disable iff (!arst_n)
		!v2_q |-> !hc_q)
		else $error("high capacity on version 1 card");

endmodule
